// ----- rtl/ipp_pkg.sv -----
// Shared types and constants for the trace-index payload parser.
`default_nettype none

package ipp_pkg;

    // Longest accepted LEB128 varint, in bytes.
    localparam int VARINT_MAX_BYTES = 10;
    localparam int VCNT_W           = $clog2(VARINT_MAX_BYTES + 1);

    // Byte counts of the fixed-size records.
    localparam int REC_BYTES        = 24;
    localparam int HIER_BYTES       = 8;
    localparam int META_BYTES       = 16;
    localparam int SKIP_BYTES       = 16;
    localparam int IDX_W            = 5;

    // Byte that opens the optional section.
    localparam logic [7:0] SENTINEL_BYTE = 8'h01;

    // Result queue depth; two slots are kept free for a beat's results.
    localparam int QUEUE_DEPTH      = 4;
    localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);

    // Packed output data: three words, status, zero fill to whole bytes.
    localparam int OUT_DATA_W       = 200;
    localparam int OUT_USED_W       = 193;

    // Result kinds.
    localparam logic [2:0] KIND_VC   = 3'd0;
    localparam logic [2:0] KIND_TXN  = 3'd1;
    localparam logic [2:0] KIND_META = 3'd2;
    localparam logic [2:0] KIND_HIER = 3'd3;
    localparam logic [2:0] KIND_END  = 3'd4;

    // Parser sections.
    typedef enum logic [3:0] {
        SEC_VC_COUNT   = 4'd0,
        SEC_VC_REC     = 4'd1,
        SEC_TXN_COUNT  = 4'd2,
        SEC_TXN_REC    = 4'd3,
        SEC_VR_COUNT   = 4'd4,
        SEC_VR_ID      = 4'd5,
        SEC_VR_SKIP    = 4'd6,
        SEC_SENTINEL   = 4'd7,
        SEC_META       = 4'd8,
        SEC_HIER_COUNT = 4'd9,
        SEC_HIER_REC   = 4'd10,
        SEC_DONE       = 4'd11
    } section_t;

    // One result item.
    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] first_word;
        logic [63:0] second_word;
        logic [63:0] third_word;
        logic        status;
        logic        last_result;
    } result_t;

    // Results produced by one payload byte: an item, then an end status.
    typedef struct packed {
        logic    item_valid;
        logic    end_valid;
        result_t item;
        result_t end_res;
    } push_t;

endpackage

`default_nettype wire

// ----- rtl/index_payload_parser.sv -----
// Top level of the trace-index payload parser: input register, parser, result queue.
// A byte is held in the input register, then its results are written into the result queue.
// Throughput: one input beat per cycle while the queue has room for two results. A beat
// yields up to two results; the queue drains one per cycle while m_tready is high.
// Reset: rst_n clears the parser to expect the value-change count and empties the queue.
`default_nettype none

module index_payload_parser (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [7:0]                     s_tdata,  // [7:0] payload_byte
    input  wire logic                           s_tlast,  // last_byte
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [63:0] first_word, [127:64] second_word, [191:128] third_word, [192] status
    output logic [ipp_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic [2:0]                          m_tuser,  // [2:0] kind
    output logic                                m_tlast   // last_result
);
    import ipp_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic        advance;
    logic        room;
    push_t       push;
    result_t     out_res;

    // The held byte moves into the parser when the queue has room for two results.
    assign advance  = in_valid_reg && room;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    ipp_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .payload_byte (in_byte_reg),
        .last_byte    (in_last_reg),
        .push         (push)
    );

    ipp_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    // Output beat packing.
    assign m_tdata = {{(OUT_DATA_W - OUT_USED_W){1'b0}}, out_res.status,
                      out_res.third_word, out_res.second_word, out_res.first_word};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last_result;

endmodule

`default_nettype wire

// ----- rtl/ipp_core.sv -----
// Parser state and the per-byte section logic of the payload parser.
`default_nettype none

module ipp_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           step,
    input  wire logic [7:0]     payload_byte,
    input  wire logic           last_byte,
    output ipp_pkg::push_t      push
);
    import ipp_pkg::*;

    section_t           section_reg, section_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [63:0]        items_reg, items_next;
    logic [63:0]        acc_reg, acc_next;
    logic [VCNT_W-1:0]  vcnt_reg, vcnt_next;
    logic [63:0]        w1_reg, w1_next;
    logic [63:0]        w2_reg, w2_next;
    logic [63:0]        w3_reg, w3_next;
    logic               err_reg, err_next;

    // Varint byte decode.
    logic [6:0]         shift;
    logic [70:0]        shifted;
    logic [63:0]        acc_new;
    logic [VCNT_W-1:0]  vcnt_new;
    logic               v_bad;
    logic               v_cont_bad;
    logic               v_done;

    // Record byte capture.
    logic [IDX_W-1:0]   idx_new;
    logic [63:0]        lane;
    logic [63:0]        w1_upd, w2_upd, w3_upd;
    logic               items_one;
    logic               end_bad;

    always_comb
    begin
        shift      = 7'({3'd0, vcnt_reg} * 7'd7);
        shifted    = {64'd0, payload_byte[6:0]} << shift;
        acc_new    = acc_reg | shifted[63:0];
        vcnt_new   = vcnt_reg + 1'b1;
        v_bad      = (vcnt_reg >= VCNT_W'(VARINT_MAX_BYTES)) || (shift >= 7'd64)
                     || (shifted[70:64] != 7'd0);
        v_cont_bad = payload_byte[7] && (vcnt_new >= VCNT_W'(VARINT_MAX_BYTES));
        v_done     = !payload_byte[7];
    end

    // Little-endian byte placement into the three record words.
    always_comb
    begin
        idx_new   = idx_reg + 1'b1;
        lane      = {56'd0, payload_byte} << {idx_reg[2:0], 3'b000};
        w1_upd    = w1_reg;
        w2_upd    = w2_reg;
        w3_upd    = w3_reg;
        case (idx_reg[4:3])
            2'd0:    w1_upd = w1_reg | lane;
            2'd1:    w2_upd = w2_reg | lane;
            default: w3_upd = w3_reg | lane;
        endcase
        items_one = (items_reg == 64'd1);
    end

    // Section logic for one byte, then the end status on the final byte.
    always_comb
    begin
        section_next = section_reg;
        idx_next     = idx_reg;
        items_next   = items_reg;
        acc_next     = acc_reg;
        vcnt_next    = vcnt_reg;
        w1_next      = w1_reg;
        w2_next      = w2_reg;
        w3_next      = w3_reg;
        err_next     = err_reg;
        push         = '0;
        end_bad      = 1'b0;

        if (step && !err_reg)
        begin
            unique case (section_reg)
                SEC_VC_COUNT, SEC_TXN_COUNT, SEC_VR_COUNT, SEC_HIER_COUNT:
                begin
                    if (v_bad || v_cont_bad)
                    begin
                        err_next = 1'b1;
                    end
                    else if (!v_done)
                    begin
                        acc_next  = acc_new;
                        vcnt_next = vcnt_new;
                    end
                    else
                    begin
                        items_next = acc_new;
                        acc_next   = '0;
                        vcnt_next  = '0;
                        w1_next    = '0;
                        w2_next    = '0;
                        w3_next    = '0;
                        idx_next   = '0;
                        unique case (section_reg)
                            SEC_VC_COUNT:
                                section_next = (acc_new == 64'd0) ? SEC_TXN_COUNT
                                                                  : SEC_VC_REC;
                            SEC_TXN_COUNT:
                                section_next = (acc_new == 64'd0) ? SEC_VR_COUNT
                                                                  : SEC_TXN_REC;
                            SEC_VR_COUNT:
                                section_next = (acc_new == 64'd0) ? SEC_SENTINEL
                                                                  : SEC_VR_ID;
                            default:
                                section_next = (acc_new == 64'd0) ? SEC_DONE
                                                                  : SEC_HIER_REC;
                        endcase
                    end
                end
                SEC_VC_REC, SEC_TXN_REC, SEC_HIER_REC:
                begin
                    if (idx_new < ((section_reg == SEC_HIER_REC) ? IDX_W'(HIER_BYTES)
                                                                 : IDX_W'(REC_BYTES)))
                    begin
                        idx_next = idx_new;
                        w1_next  = w1_upd;
                        w2_next  = w2_upd;
                        w3_next  = w3_upd;
                    end
                    else
                    begin
                        push.item_valid       = 1'b1;
                        push.item.first_word  = w1_upd;
                        if (section_reg == SEC_HIER_REC)
                        begin
                            push.item.kind = KIND_HIER;
                        end
                        else
                        begin
                            push.item.kind        = (section_reg == SEC_VC_REC) ? KIND_VC
                                                                                : KIND_TXN;
                            push.item.second_word = w2_upd;
                            push.item.third_word  = w3_upd;
                        end
                        w1_next    = '0;
                        w2_next    = '0;
                        w3_next    = '0;
                        idx_next   = '0;
                        items_next = items_reg - 64'd1;
                        if (items_one)
                        begin
                            unique case (section_reg)
                                SEC_VC_REC:  section_next = SEC_TXN_COUNT;
                                SEC_TXN_REC: section_next = SEC_VR_COUNT;
                                default:     section_next = SEC_DONE;
                            endcase
                        end
                    end
                end
                SEC_VR_ID:
                begin
                    if (v_bad || v_cont_bad)
                    begin
                        err_next = 1'b1;
                    end
                    else if (!v_done)
                    begin
                        acc_next  = acc_new;
                        vcnt_next = vcnt_new;
                    end
                    else
                    begin
                        acc_next     = '0;
                        vcnt_next    = '0;
                        idx_next     = '0;
                        section_next = SEC_VR_SKIP;
                    end
                end
                SEC_VR_SKIP:
                begin
                    if (idx_new < IDX_W'(SKIP_BYTES))
                    begin
                        idx_next = idx_new;
                    end
                    else
                    begin
                        idx_next     = '0;
                        items_next   = items_reg - 64'd1;
                        section_next = items_one ? SEC_SENTINEL : SEC_VR_ID;
                    end
                end
                SEC_SENTINEL:
                begin
                    if (payload_byte == SENTINEL_BYTE)
                    begin
                        w1_next      = '0;
                        w2_next      = '0;
                        w3_next      = '0;
                        idx_next     = '0;
                        section_next = SEC_META;
                    end
                    else
                    begin
                        section_next = SEC_DONE;
                    end
                end
                SEC_META:
                begin
                    if (idx_new < IDX_W'(META_BYTES))
                    begin
                        idx_next = idx_new;
                        w1_next  = w1_upd;
                        w2_next  = w2_upd;
                    end
                    else
                    begin
                        push.item_valid       = 1'b1;
                        push.item.kind        = KIND_META;
                        push.item.first_word  = w1_upd;
                        push.item.second_word = w2_upd;
                        w1_next      = '0;
                        w2_next      = '0;
                        w3_next      = '0;
                        idx_next     = '0;
                        section_next = SEC_HIER_COUNT;
                    end
                end
                default:
                begin
                    section_next = SEC_DONE;
                end
            endcase
        end

        // The final byte closes the run and returns the parser to its start.
        if (step && last_byte)
        begin
            end_bad = err_next || ((section_next != SEC_SENTINEL) &&
                                   (section_next != SEC_DONE));
            push.end_valid           = 1'b1;
            push.end_res.kind        = KIND_END;
            push.end_res.status      = end_bad;
            push.end_res.last_result = 1'b1;
            section_next = SEC_VC_COUNT;
            idx_next     = '0;
            items_next   = '0;
            acc_next     = '0;
            vcnt_next    = '0;
            w1_next      = '0;
            w2_next      = '0;
            w3_next      = '0;
            err_next     = 1'b0;
        end
    end

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            section_reg <= SEC_VC_COUNT;
            idx_reg     <= '0;
            items_reg   <= '0;
            acc_reg     <= '0;
            vcnt_reg    <= '0;
            w1_reg      <= '0;
            w2_reg      <= '0;
            w3_reg      <= '0;
            err_reg     <= 1'b0;
        end
        else
        begin
            section_reg <= section_next;
            idx_reg     <= idx_next;
            items_reg   <= items_next;
            acc_reg     <= acc_next;
            vcnt_reg    <= vcnt_next;
            w1_reg      <= w1_next;
            w2_reg      <= w2_next;
            w3_reg      <= w3_next;
            err_reg     <= err_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ipp_out_queue.sv -----
// Result queue that takes up to two results per cycle and returns one per beat.
`default_nettype none

module ipp_out_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire ipp_pkg::push_t   push,
    output logic                  room,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output ipp_pkg::result_t      out_res
);
    import ipp_pkg::*;

    result_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic [QPTR_W-1:0]   end_ptr;
    logic [1:0]          push_n;
    logic                pop;

    // Pointer and fill bookkeeping.
    always_comb
    begin
        pop         = out_valid && out_ready;
        push_n      = {1'b0, push.item_valid} + {1'b0, push.end_valid};
        end_ptr     = push.item_valid ? (wr_ptr_reg + 1'b1) : wr_ptr_reg;
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push_n);
        rd_ptr_next = pop ? (rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push_n) - QCNT_W'(pop);
    end

    assign room      = (count_reg <= QCNT_W'(QUEUE_DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_res   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage: the item goes first, the end status right behind it.
    always_ff @(posedge clk)
    begin
        if (push.item_valid)
        begin
            entry_reg[wr_ptr_reg] <= push.item;
        end
        if (push.end_valid)
        begin
            entry_reg[end_ptr] <= push.end_res;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ipp_checker.sv -----
// Port-level checks for the payload parser and their binding to the top level.
`default_nettype none

module ipp_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic [ipp_pkg::OUT_DATA_W-1:0] m_tdata,
    input  wire logic [2:0]                     m_tuser,
    input  wire logic                           m_tlast
);
    import ipp_pkg::*;

    // A stalled output beat holds its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("output beat changed while stalled");

    // The last beat of a run is the end status and carries no words.
    a_end_beat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> (m_tuser == KIND_END) && (m_tdata[191:0] == 192'd0))
        else $error("end beat has wrong kind or nonzero words");

    // Status is reported only on the end beat.
    a_status_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> (m_tdata[192] == 1'b0) && (m_tuser != KIND_END))
        else $error("status or end kind on a non-final beat");

    // Hierarchy offsets and metadata carry no trailing words.
    a_short_kinds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ((m_tuser == KIND_HIER) || (m_tuser == KIND_META))
            |-> (m_tdata[191:128] == 64'd0)
                && ((m_tuser == KIND_META) || (m_tdata[127:64] == 64'd0)))
        else $error("unused words nonzero in short result");

endmodule

bind index_payload_parser ipp_checker u_ipp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ----- bench/index_payload_checker.sv -----
// Watches both streams of the index payload parser, predicts its results and compares them.
module index_payload_checker
    import ipp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [7:0]            s_tdata,
    input  logic                  s_tlast,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic [2:0]            m_tuser,
    input  logic                  m_tlast,
    output int                    mismatches,
    output int                    outstanding
);

    // Parser state kept alongside the block.
    section_t    sec;
    logic [4:0]  byte_idx;
    logic [63:0] items_left;
    logic [63:0] vint_acc;
    int unsigned vint_bytes;
    logic [63:0] word_a;
    logic [63:0] word_b;
    logic [63:0] word_c;
    bit          corrupt;

    // Index entries and end statuses still to come out of the block, oldest first.
    result_t entries_due[$];

    function automatic void reset_words();
        word_a   = '0;
        word_b   = '0;
        word_c   = '0;
        byte_idx = '0;
    endfunction

    function automatic void reset_parser();
        sec        = SEC_VC_COUNT;
        items_left = '0;
        vint_acc   = '0;
        vint_bytes = 0;
        corrupt    = 1'b0;
        reset_words();
    endfunction

    function automatic void emit(input logic [2:0] kind, input logic [63:0] first,
                                 input logic [63:0] second, input logic [63:0] third,
                                 input logic st, input logic fin);
        result_t r;
        r.kind        = kind;
        r.first_word  = first;
        r.second_word = second;
        r.third_word  = third;
        r.status      = st;
        r.last_result = fin;
        entries_due.push_back(r);
    endfunction

    // Adds one LEB128 byte: -1 corrupt, 0 more bytes needed, 1 complete.
    function automatic int feed_varint(input logic [7:0] data);
        int unsigned shift;
        logic [63:0] part;
        shift = vint_bytes * 7;
        part  = {57'b0, data[6:0]};
        if (vint_bytes >= VARINT_MAX_BYTES || shift >= 64)
            return -1;
        // Bits that would fall above bit 63.
        if (shift > 57 && (part >> (64 - shift)) != 0)
            return -1;
        vint_acc   = vint_acc | (part << shift);
        vint_bytes = vint_bytes + 1;
        if (data[7])
            return (vint_bytes >= VARINT_MAX_BYTES) ? -1 : 0;
        return 1;
    endfunction

    // Little-endian byte into the current record word.
    function automatic void store_byte(input logic [7:0] data);
        logic [63:0] v;
        v = 64'(data) << {byte_idx[2:0], 3'b000};
        case (byte_idx[4:3])
            2'd0:    word_a = word_a | v;
            2'd1:    word_b = word_b | v;
            default: word_c = word_c | v;
        endcase
        byte_idx = byte_idx + 1'b1;
    endfunction

    function automatic void parse_index_byte(input logic [7:0] data);
        int       r;
        section_t rec_sec;
        section_t none_sec;
        case (sec)
            SEC_VC_COUNT, SEC_TXN_COUNT, SEC_VR_COUNT, SEC_HIER_COUNT:
            begin
                r = feed_varint(data);
                if (r < 0)
                begin
                    corrupt = 1'b1;
                end
                else if (r > 0)
                begin
                    items_left = vint_acc;
                    vint_acc   = '0;
                    vint_bytes = 0;
                    reset_words();
                    case (sec)
                        SEC_VC_COUNT:
                        begin
                            rec_sec  = SEC_VC_REC;
                            none_sec = SEC_TXN_COUNT;
                        end
                        SEC_TXN_COUNT:
                        begin
                            rec_sec  = SEC_TXN_REC;
                            none_sec = SEC_VR_COUNT;
                        end
                        SEC_VR_COUNT:
                        begin
                            rec_sec  = SEC_VR_ID;
                            none_sec = SEC_SENTINEL;
                        end
                        default:
                        begin
                            rec_sec  = SEC_HIER_REC;
                            none_sec = SEC_DONE;
                        end
                    endcase
                    sec = (items_left == 0) ? none_sec : rec_sec;
                end
            end
            SEC_VC_REC, SEC_TXN_REC, SEC_HIER_REC:
            begin
                store_byte(data);
                if (byte_idx == ((sec == SEC_HIER_REC) ? HIER_BYTES : REC_BYTES))
                begin
                    if (sec == SEC_HIER_REC)
                        emit(KIND_HIER, word_a, '0, '0, 1'b0, 1'b0);
                    else
                        emit((sec == SEC_VC_REC) ? KIND_VC : KIND_TXN,
                             word_a, word_b, word_c, 1'b0, 1'b0);
                    reset_words();
                    items_left = items_left - 1;
                    if (items_left == 0)
                    begin
                        if (sec == SEC_VC_REC)
                            sec = SEC_TXN_COUNT;
                        else if (sec == SEC_TXN_REC)
                            sec = SEC_VR_COUNT;
                        else
                            sec = SEC_DONE;
                    end
                end
            end
            SEC_VR_ID:
            begin
                r = feed_varint(data);
                if (r < 0)
                begin
                    corrupt = 1'b1;
                end
                else if (r > 0)
                begin
                    vint_acc   = '0;
                    vint_bytes = 0;
                    byte_idx   = '0;
                    sec        = SEC_VR_SKIP;
                end
            end
            SEC_VR_SKIP:
            begin
                byte_idx = byte_idx + 1'b1;
                if (byte_idx == SKIP_BYTES)
                begin
                    byte_idx   = '0;
                    items_left = items_left - 1;
                    sec        = (items_left == 0) ? SEC_SENTINEL : SEC_VR_ID;
                end
            end
            SEC_SENTINEL:
            begin
                // Anything but the sentinel closes the payload quietly.
                if (data == SENTINEL_BYTE)
                begin
                    reset_words();
                    sec = SEC_META;
                end
                else
                begin
                    sec = SEC_DONE;
                end
            end
            SEC_META:
            begin
                store_byte(data);
                if (byte_idx == META_BYTES)
                begin
                    emit(KIND_META, word_a, word_b, '0, 1'b0, 1'b0);
                    reset_words();
                    sec = SEC_HIER_COUNT;
                end
            end
            default:
            begin
                sec = SEC_DONE;
            end
        endcase
    endfunction

    // One accepted input beat; the final byte always closes with an end status.
    function automatic void take_beat(input logic [7:0] data, input logic fin);
        logic bad;
        if (!corrupt)
            parse_index_byte(data);
        if (fin)
        begin
            bad = corrupt || (sec != SEC_SENTINEL && sec != SEC_DONE);
            emit(KIND_END, '0, '0, '0, bad, 1'b1);
            reset_parser();
        end
    endfunction

    task automatic report(input string msg);
        if (mismatches < 100)
            $display("ERROR at %0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report($sformatf("%s got %h, expected %h", name, got, want));
    endtask

    task automatic compare_result();
        result_t want;
        if (entries_due.size() == 0)
        begin
            report($sformatf("result beat of kind %0d with nothing due", m_tuser));
        end
        else
        begin
            want = entries_due.pop_front();
            check_field("kind", 64'(m_tuser), 64'(want.kind));
            check_field("first_word", m_tdata[63:0], want.first_word);
            check_field("second_word", m_tdata[127:64], want.second_word);
            check_field("third_word", m_tdata[191:128], want.third_word);
            check_field("status", 64'(m_tdata[192]), 64'(want.status));
            check_field("last_result", 64'(m_tlast), 64'(want.last_result));
        end
    endtask

    // Input beats are predicted first; their results cannot leave in the same cycle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_parser();
            entries_due.delete();
            outstanding <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                take_beat(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                compare_result();
            outstanding <= entries_due.size();
        end
    end

endmodule

// ----- bench/tb.sv -----
// Testbench top for the index payload parser: stimulus, back-pressure and final verdict.
module tb;
    import ipp_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 300;
    localparam int BYTE_TARGET = 800;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [7:0]            s_tdata  = 8'h00;
    logic                  s_tlast  = 1'b0;
    logic                  m_tready = 1'b0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [2:0]            m_tuser;
    logic                  m_tlast;

    int mismatches;
    int outstanding;
    int cycles;

    // Shared between stimulus and the output side.
    bit quiet;
    bit hold_off;

    // Payload under construction, and which of its varints gets corrupted.
    logic [7:0] payload[$];
    int         vint_no;
    int         bad_vint_at;

    always #4 clk = ~clk;

    index_payload_parser u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    index_payload_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Mostly no gap, sometimes a short one, rarely a long one.
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    function automatic logic [7:0] rand_byte();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hff;
        return 8'($urandom);
    endfunction

    function automatic logic [63:0] rand_wide();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return {$urandom, $urandom} >> $urandom_range(0, 63);
    endfunction

    function automatic int pick_count();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return 0;
        if (r < 7)
            return 1;
        if (r < 9)
            return 2;
        return 3;
    endfunction

    // Redundant continuation bytes on some varints.
    function automatic int pad_len();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
    endfunction

    function automatic void add_random_bytes(input int n);
        repeat (n) payload.push_back(rand_byte());
    endfunction

    // Either overlong (continuation still set on the last allowed byte) or past 64 bits.
    function automatic void add_corrupt_varint();
        if ($urandom_range(0, 1))
        begin
            repeat (VARINT_MAX_BYTES - 1) payload.push_back(8'h80 | 8'($urandom));
            payload.push_back(8'h80 | 8'($urandom_range(0, 1)));
        end
        else
        begin
            repeat (VARINT_MAX_BYTES - 1) payload.push_back(8'h80 | 8'($urandom));
            payload.push_back(8'($urandom_range(2, 255)));
        end
    endfunction

    function automatic void add_varint(input logic [63:0] value, input int pad);
        int         len;
        int         total;
        logic [7:0] b;
        vint_no++;
        if (vint_no - 1 == bad_vint_at)
        begin
            add_corrupt_varint();
            return;
        end
        len = 1;
        while (len < VARINT_MAX_BYTES && (value >> (7 * len)) != 0)
            len++;
        total = (len + pad > VARINT_MAX_BYTES) ? VARINT_MAX_BYTES : len + pad;
        for (int i = 0; i < total; i++)
        begin
            b    = 8'(value >> (7 * i));
            b[7] = (i < total - 1);
            payload.push_back(b);
        end
    endfunction

    // An index payload with random sizes and content; well-formed unless bad_vint_at picks a varint to corrupt.
    function automatic void build_index();
        int n;
        int r;
        n = pick_count();
        add_varint(64'(n), pad_len());
        add_random_bytes(n * REC_BYTES);
        n = pick_count();
        add_varint(64'(n), pad_len());
        add_random_bytes(n * REC_BYTES);
        n = pick_count();
        add_varint(64'(n), pad_len());
        repeat (n)
        begin
            add_varint(rand_wide(), pad_len());
            add_random_bytes(SKIP_BYTES);
        end
        r = $urandom_range(0, 9);
        if (r >= 4 && r < 8)
        begin
            payload.push_back(SENTINEL_BYTE);
            add_random_bytes(META_BYTES);
            n = $urandom_range(0, 4);
            add_varint(64'(n), pad_len());
            add_random_bytes(n * HIER_BYTES);
        end
        else if (r >= 8)
        begin
            payload.push_back(SENTINEL_BYTE ^ 8'($urandom_range(1, 255)));
        end
        // Trailing bytes past the end of the payload.
        if ($urandom_range(0, 3) == 0)
            add_random_bytes($urandom_range(1, 4));
    endfunction

    task automatic send_byte(input logic [7:0] data, input logic fin);
        int idle;
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= fin;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        idle = quiet ? 0 : gap_length();
        if (idle > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
    endtask

    task automatic send_payload();
        int n;
        n = payload.size();
        for (int i = 0; i < n; i++)
            send_byte(payload[i], i == n - 1);
        payload.delete();
    endtask

    // Output side: ready bursts broken by random stalls, and a long hold-off on request.
    initial
    begin : sink
        int busy;
        int idle;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            busy = $urandom_range(1, 12);
            m_tready <= 1'b1;
            repeat (busy) @(posedge clk);
            if (hold_off)
            begin
                hold_off = 1'b0;
                idle     = HOLD_CYCLES;
            end
            else
            begin
                idle = quiet ? 0 : gap_length();
            end
            if (idle > 0)
            begin
                m_tready <= 1'b0;
                repeat (idle) @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        int sent;
        int payloads;
        int mode;
        bad_vint_at = -1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Shortest good payload: all counts zero, ends where the optional part may begin.
        payload.push_back(8'h00); payload.push_back(8'h00); payload.push_back(8'h00);
        send_payload();
        // Ends inside the value-change records.
        payload.push_back(8'h05);
        send_payload();
        // No sentinel where the optional part may begin, then trailing bytes.
        payload.push_back(8'h00); payload.push_back(8'h00); payload.push_back(8'h00);
        payload.push_back(8'h02); payload.push_back(8'haa);
        send_payload();
        // Continuation bit still set on the tenth varint byte.
        repeat (9) payload.push_back(8'hff);
        payload.push_back(8'h81);
        send_payload();
        // Largest count a varint can hold, then the payload stops.
        repeat (9) payload.push_back(8'hff);
        payload.push_back(8'h01);
        send_payload();

        sent     = 0;
        payloads = 0;
        while (sent < BYTE_TARGET)
        begin
            quiet       = ($urandom_range(0, 5) == 0);
            vint_no     = 0;
            bad_vint_at = -1;
            if (payloads == 2 || payloads == 9)
                hold_off = 1'b1;
            mode = $urandom_range(0, 19);
            if (mode <= 10 || mode == 19)
            begin
                build_index();
            end
            else if (mode <= 13)
            begin
                // Cut short at a random point.
                build_index();
                mode = $urandom_range(1, payload.size());
                while (payload.size() > mode)
                    void'(payload.pop_back());
            end
            else if (mode <= 16)
            begin
                bad_vint_at = $urandom_range(0, 4);
                build_index();
            end
            else if (mode == 17)
            begin
                // Huge count in one of the counted sections, never satisfied.
                repeat ($urandom_range(0, 2)) payload.push_back(8'h00);
                add_varint(rand_wide() | 64'd64, pad_len());
                add_random_bytes($urandom_range(0, 30));
            end
            else
            begin
                add_random_bytes($urandom_range(1, 24));
            end
            sent += payload.size();
            payloads++;
            send_payload();
        end
        s_tvalid <= 1'b0;
        quiet = 1'b0;

        @(posedge clk);
        wait (outstanding == 0);
        repeat (16) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
